// File: rtl/cocp_pkg.sv
// ----------------------------------------------------------------------------
// cocp_pkg
// shared types, constants and tables of the orbit camera position core
// ----------------------------------------------------------------------------
package cocp_pkg;

  // angle units: 1/128 degree, one turn = 46080
  localparam int TURN         = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  // multiple of a turn that lifts any wrap operand above zero
  localparam int ANGLE_BIAS   = 256 * TURN;

  // binary angle conversion: z = mag * DIV_MUL + (mag * DIV_REM_MUL + DIV_ADD) / DIV_CONST
  localparam int DIV_MUL      = 93206;
  localparam int DIV_REM_MUL  = 34;
  localparam int DIV_ADD      = 22;
  localparam int DIV_CONST    = 45;

  // shared reducer geometry
  localparam int RED_W        = 24;
  localparam int QUO_W        = 14;
  localparam int WRAP_TOP_K   = 7;
  localparam int DIV_TOP_K    = 13;

  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_GAIN  = 652032874;

  // command codes
  localparam logic [2:0] CMD_ORBIT  = 3'd0;
  localparam logic [2:0] CMD_PITCH  = 3'd1;
  localparam logic [2:0] CMD_ZOOM   = 3'd2;
  localparam logic [2:0] CMD_UPDATE = 3'd3;
  localparam logic [2:0] CMD_INIT   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_PITCH_LOW  = 3'd0;
  localparam logic [2:0] REG_PITCH_HIGH = 3'd1;
  localparam logic [2:0] REG_DIST_MAX   = 3'd2;
  localparam logic [2:0] REG_DIST_MIN   = 3'd3;
  localparam logic [2:0] REG_INIT_PITCH = 3'd4;
  localparam logic [2:0] REG_INIT_DIST  = 3'd5;
  localparam logic [2:0] REG_INIT_ORBIT = 3'd6;

  // multiplier sequence steps
  localparam logic [2:0] MUL_H   = 3'd0;
  localparam logic [2:0] MUL_V   = 3'd1;
  localparam logic [2:0] MUL_OX  = 3'd2;
  localparam logic [2:0] MUL_OZ  = 3'd3;
  localparam logic [2:0] MUL_POS = 3'd4;

  typedef enum logic [2:0] {
    SRC_ORBIT_DELTA = 3'd0,
    SRC_INIT_ORBIT  = 3'd1,
    SRC_YAW_ORBIT   = 3'd2,
    SRC_PITCH       = 3'd3,
    SRC_DIV         = 3'd4
  } red_src_e;

  typedef struct packed {
    logic       load_in;
    logic       red_start;
    red_src_e   red_src;
    logic       wr_orbit;
    logic       wr_heading;
    logic       cordic_start;
    logic       trig_store;
    logic       trig_sel;
    logic       mul_step;
    logic [2:0] mul_idx;
    logic       apply_pitch;
    logic       apply_zoom;
    logic       apply_init;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic red_done;
    logic cordic_done;
  } dp_stat_t;

  // atan(2^-i) with one turn = 2^32
  function automatic logic [30:0] atan_turn32(input logic [4:0] idx);
    logic [30:0] r;
    case (idx)
      5'd0:    r = 31'd536870912;
      5'd1:    r = 31'd316933406;
      5'd2:    r = 31'd167458907;
      5'd3:    r = 31'd85004756;
      5'd4:    r = 31'd42667331;
      5'd5:    r = 31'd21354465;
      5'd6:    r = 31'd10679838;
      5'd7:    r = 31'd5340245;
      5'd8:    r = 31'd2670163;
      5'd9:    r = 31'd1335087;
      5'd10:   r = 31'd667544;
      5'd11:   r = 31'd333772;
      5'd12:   r = 31'd166886;
      5'd13:   r = 31'd83443;
      5'd14:   r = 31'd41722;
      5'd15:   r = 31'd20861;
      5'd16:   r = 31'd10430;
      5'd17:   r = 31'd5215;
      5'd18:   r = 31'd2608;
      5'd19:   r = 31'd1304;
      5'd20:   r = 31'd652;
      5'd21:   r = 31'd326;
      5'd22:   r = 31'd163;
      5'd23:   r = 31'd81;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/cocp_reducer.sv
// ----------------------------------------------------------------------------
// cocp_reducer
// shared compare-and-subtract unit: wraps angles to one turn or divides by 45
// ----------------------------------------------------------------------------
module cocp_reducer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      div_mode_i,
  input  logic [cocp_pkg::RED_W-1:0] value_i,
  output logic                      done_o,
  output logic [cocp_pkg::RED_W-1:0] rem_o,
  output logic [cocp_pkg::QUO_W-1:0] quo_o
);
  import cocp_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic             mode_q;
  logic [3:0]       k_q;
  logic [RED_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [RED_W:0]   step_c;
  logic             fits_c;

  always_comb begin
    if (mode_q) begin
      step_c = (25'(DIV_CONST)) << k_q;
    end else begin
      step_c = (25'(TURN)) << k_q;
    end
    fits_c = ({1'b0, rem_q} >= step_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      mode_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        mode_q <= div_mode_i;
        k_q    <= div_mode_i ? 4'(DIV_TOP_K) : 4'(WRAP_TOP_K);
      end else if (busy_q) begin
        if (k_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          k_q <= k_q - 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i;
      quo_q <= '0;
    end else if (busy_q && fits_c) begin
      rem_q     <= rem_q - step_c[RED_W-1:0];
      quo_q[k_q] <= 1'b1;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
  assign quo_o  = quo_q;

  a_wrap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !mode_q) |-> (rem_q < 24'(TURN)))
    else $error("wrapped angle not below one turn");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("reducer started while busy");

endmodule

// File: rtl/cocp_cordic.sv
// ----------------------------------------------------------------------------
// cocp_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle, q2.30
// ----------------------------------------------------------------------------
module cocp_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] z_i,
  output logic               done_o,
  output logic signed [33:0] x_o,
  output logic signed [33:0] y_o
);
  import cocp_pkg::*;

  localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int IW    = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic              busy_q;
  logic              done_q;
  logic [IW-1:0]     i_q;
  logic signed [33:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic signed [33:0] dx_c, dy_c;
  logic signed [32:0] atan_c;

  always_comb begin
    dx_c   = y_q >>> i_q;
    dy_c   = x_q >>> i_q;
    atan_c = signed'(33'(atan_turn32(5'(i_q))));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        if (i_q == IW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= 34'(CORDIC_GAIN);
      y_q <= '0;
      z_q <= z_i;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - dx_c;
        y_q <= y_q + dy_c;
        z_q <= z_q - atan_c;
      end else begin
        x_q <= x_q + dx_c;
        y_q <= y_q - dy_c;
        z_q <= z_q + atan_c;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

// File: rtl/cocp_datapath.sv
// ----------------------------------------------------------------------------
// cocp_datapath
// camera state, config registers, angle prep, shared multiplier, result beat
// ----------------------------------------------------------------------------
module cocp_datapath #(
  parameter int TRIG_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cocp_pkg::dp_cmd_t   cmd_i,
  output cocp_pkg::dp_stat_t  stat_o,
  input  logic signed [23:0]  delta_i,
  input  logic signed [16:0]  yaw_i,
  input  logic signed [31:0]  px_i,
  input  logic signed [31:0]  py_i,
  input  logic signed [31:0]  pz_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [23:0]         cfg_data_i,
  output logic signed [31:0]  cam_x_o,
  output logic signed [31:0]  cam_y_o,
  output logic signed [31:0]  cam_z_o,
  output logic [15:0]         heading_o
);
  import cocp_pkg::*;

  localparam int SH = 31 - TRIG_BITS;
  localparam int PW = 27 + TRIG_BITS;
  localparam logic signed [34:0] TRIG_HI = (35'sd1 <<< (TRIG_BITS - 1)) - 35'sd1;
  localparam logic signed [34:0] TRIG_LO = -(35'sd1 <<< (TRIG_BITS - 1));

  // config registers
  logic signed [14:0] pitch_low_q, pitch_high_q, init_pitch_q;
  logic [23:0]        dist_max_q, dist_min_q, init_dist_q;
  logic [15:0]        init_orbit_q;

  // camera state
  logic signed [15:0] pitch_q;
  logic [23:0]        dist_q;
  logic [15:0]        orbit_q, heading_q;
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;

  // captured item
  logic signed [23:0] delta_q;
  logic signed [16:0] yaw_q;
  logic signed [31:0] px_q, py_q, pz_q;

  // trig working registers
  logic [13:0]                mag_q;
  logic                       neg_q, flip_q;
  logic signed [TRIG_BITS-1:0] sp_q, cp_q, st_q, ct_q;
  logic signed [25:0]         h_q, v_q;
  logic signed [26:0]         ox_q, oz_q;

  // result beat
  logic signed [31:0] out_x_q, out_y_q, out_z_q;
  logic [15:0]        out_h_q;

  // shared units
  logic [RED_W-1:0]   red_value_c, red_rem;
  logic [QUO_W-1:0]   red_quo;
  logic               red_done, cor_done;
  logic signed [33:0] cor_x, cor_y;
  logic signed [32:0] z_c;

  // angle prep
  logic signed [25:0] ang_sum_c, ang_bias_c;
  logic [15:0]        ang_c;
  logic signed [17:0] a2_c, a3_c, aabs_c;
  logic               flip_c, neg_c;
  logic [13:0]        mag_c;
  logic [18:0]        dividend_c;
  logic [31:0]        zmag_c;

  // trig rounding
  logic signed [33:0] cx_f, cy_f;
  logic signed [34:0] cx_r, cy_r;
  logic signed [TRIG_BITS-1:0] cos_c, sin_c;

  // multiplier
  logic signed [25:0]          mul_a;
  logic signed [TRIG_BITS-1:0] mul_b;
  logic signed [PW-1:0]        prod_c, prod_r;

  // immediate updates
  logic signed [24:0] pitch_sum_c;
  logic signed [25:0] dist_sum_c;
  logic signed [33:0] dx_c, dy_c, dz_c;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    case (cmd_i.red_src)
      SRC_ORBIT_DELTA: ang_sum_c = signed'(26'({1'b0, orbit_q})) + 26'(delta_q);
      SRC_INIT_ORBIT:  ang_sum_c = signed'(26'({1'b0, init_orbit_q}));
      SRC_YAW_ORBIT:   ang_sum_c = 26'(yaw_q) + signed'(26'({1'b0, orbit_q}));
      SRC_PITCH:       ang_sum_c = 26'(pitch_q);
      default:         ang_sum_c = '0;
    endcase
    ang_bias_c = (ang_sum_c < 0) ? ang_sum_c + 26'(ANGLE_BIAS) : ang_sum_c;

    // fold the wrapped angle into [-90, 90] degrees
    ang_c = red_rem[15:0];
    if (ang_c >= 16'(HALF_TURN)) begin
      a2_c = signed'({2'b00, ang_c}) - 18'(TURN);
    end else begin
      a2_c = signed'({2'b00, ang_c});
    end
    flip_c = 1'b0;
    a3_c   = a2_c;
    if (a2_c > 18'(QUARTER_TURN)) begin
      a3_c   = a2_c - 18'(HALF_TURN);
      flip_c = 1'b1;
    end else if (a2_c < -18'(QUARTER_TURN)) begin
      a3_c   = a2_c + 18'(HALF_TURN);
      flip_c = 1'b1;
    end
    neg_c      = (a3_c < 0);
    aabs_c     = neg_c ? -a3_c : a3_c;
    mag_c      = aabs_c[13:0];
    dividend_c = 19'(mag_c) * 19'(DIV_REM_MUL) + 19'(DIV_ADD);

    red_value_c = (cmd_i.red_src == SRC_DIV) ? RED_W'(dividend_c) : ang_bias_c[RED_W-1:0];

    zmag_c = 32'(mag_q) * 32'(DIV_MUL) + 32'(red_quo);
    z_c    = neg_q ? -signed'({1'b0, zmag_c}) : signed'({1'b0, zmag_c});

    // sign flip, round half up, saturate
    cx_f = flip_q ? -cor_x : cor_x;
    cy_f = flip_q ? -cor_y : cor_y;
    cx_r = (35'(cx_f) + (35'sd1 <<< (SH - 1))) >>> SH;
    cy_r = (35'(cy_f) + (35'sd1 <<< (SH - 1))) >>> SH;
    if (cx_r > TRIG_HI) begin
      cos_c = TRIG_HI[TRIG_BITS-1:0];
    end else if (cx_r < TRIG_LO) begin
      cos_c = TRIG_LO[TRIG_BITS-1:0];
    end else begin
      cos_c = cx_r[TRIG_BITS-1:0];
    end
    if (cy_r > TRIG_HI) begin
      sin_c = TRIG_HI[TRIG_BITS-1:0];
    end else if (cy_r < TRIG_LO) begin
      sin_c = TRIG_LO[TRIG_BITS-1:0];
    end else begin
      sin_c = cy_r[TRIG_BITS-1:0];
    end

    case (cmd_i.mul_idx)
      MUL_H: begin
        mul_a = signed'({2'b00, dist_q});
        mul_b = cp_q;
      end
      MUL_V: begin
        mul_a = signed'({2'b00, dist_q});
        mul_b = sp_q;
      end
      MUL_OX: begin
        mul_a = h_q;
        mul_b = st_q;
      end
      MUL_OZ: begin
        mul_a = h_q;
        mul_b = ct_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_c = PW'(mul_a) * PW'(mul_b);
    prod_r = (prod_c + (PW'(1) <<< (TRIG_BITS - 2))) >>> (TRIG_BITS - 1);

    pitch_sum_c = 25'(pitch_q) + 25'(delta_q);
    dist_sum_c  = signed'(26'({1'b0, dist_q})) + 26'(delta_q);
    dx_c        = 34'(px_q) - 34'(ox_q);
    dy_c        = 34'(py_q) + 34'(v_q);
    dz_c        = 34'(pz_q) - 34'(oz_q);
  end

  cocp_reducer u_reducer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.red_start),
    .div_mode_i (cmd_i.red_src == SRC_DIV),
    .value_i    (red_value_c),
    .done_o     (red_done),
    .rem_o      (red_rem),
    .quo_o      (red_quo)
  );

  cocp_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .z_i     (z_c),
    .done_o  (cor_done),
    .x_o     (cor_x),
    .y_o     (cor_y)
  );

  // config and camera state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_low_q  <= -15'sd11520;
      pitch_high_q <= 15'sd11520;
      dist_max_q   <= 24'hFF_FFFF;
      dist_min_q   <= '0;
      init_pitch_q <= '0;
      init_dist_q  <= '0;
      init_orbit_q <= '0;
      pitch_q      <= '0;
      dist_q       <= '0;
      orbit_q      <= '0;
      heading_q    <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      pos_z_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PITCH_LOW:  pitch_low_q  <= cfg_data_i[14:0];
          REG_PITCH_HIGH: pitch_high_q <= cfg_data_i[14:0];
          REG_DIST_MAX:   dist_max_q   <= cfg_data_i;
          REG_DIST_MIN:   dist_min_q   <= cfg_data_i;
          REG_INIT_PITCH: init_pitch_q <= cfg_data_i[14:0];
          REG_INIT_DIST:  init_dist_q  <= cfg_data_i;
          REG_INIT_ORBIT: init_orbit_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.apply_pitch) begin
        if (!((pitch_sum_c <= 25'(pitch_low_q)) || (pitch_sum_c > 25'(pitch_high_q)))) begin
          pitch_q <= pitch_sum_c[15:0];
        end
      end
      if (cmd_i.apply_zoom) begin
        // upper clamp wins when the limits cross
        if (dist_sum_c > signed'({2'b00, dist_max_q})) begin
          dist_q <= dist_max_q;
        end else if (dist_sum_c < signed'({2'b00, dist_min_q})) begin
          dist_q <= dist_min_q;
        end else begin
          dist_q <= dist_sum_c[23:0];
        end
      end
      if (cmd_i.apply_init) begin
        pitch_q <= 16'(init_pitch_q);
        dist_q  <= init_dist_q;
        pos_x_q <= px_q;
        pos_y_q <= py_q;
        pos_z_q <= pz_q;
      end
      if (cmd_i.wr_orbit) begin
        orbit_q <= red_rem[15:0];
      end
      if (cmd_i.wr_heading) begin
        heading_q <= red_rem[15:0];
      end
      if (cmd_i.mul_step && (cmd_i.mul_idx == MUL_POS)) begin
        pos_x_q <= sat32(dx_c);
        pos_y_q <= sat32(dy_c);
        pos_z_q <= sat32(dz_c);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      delta_q <= delta_i;
      yaw_q   <= yaw_i;
      px_q    <= px_i;
      py_q    <= py_i;
      pz_q    <= pz_i;
    end
    if (cmd_i.red_start && (cmd_i.red_src == SRC_DIV)) begin
      mag_q  <= mag_c;
      neg_q  <= neg_c;
      flip_q <= flip_c;
    end
    if (cmd_i.trig_store) begin
      if (cmd_i.trig_sel) begin
        st_q <= sin_c;
        ct_q <= cos_c;
      end else begin
        sp_q <= sin_c;
        cp_q <= cos_c;
      end
    end
    if (cmd_i.mul_step) begin
      case (cmd_i.mul_idx)
        MUL_H:   h_q  <= prod_r[25:0];
        MUL_V:   v_q  <= prod_r[25:0];
        MUL_OX:  ox_q <= prod_r[26:0];
        MUL_OZ:  oz_q <= prod_r[26:0];
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      out_x_q <= pos_x_q;
      out_y_q <= pos_y_q;
      out_z_q <= pos_z_q;
      out_h_q <= heading_q;
    end
  end

  assign stat_o.red_done    = red_done;
  assign stat_o.cordic_done = cor_done;
  assign cam_x_o   = out_x_q;
  assign cam_y_o   = out_y_q;
  assign cam_z_o   = out_z_q;
  assign heading_o = out_h_q;

endmodule

// File: rtl/cocp_ctrl.sv
// ----------------------------------------------------------------------------
// cocp_ctrl
// sequencer: decodes each command and steps the datapath through it
// ----------------------------------------------------------------------------
module cocp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  input  logic [2:0]         command_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output cocp_pkg::dp_cmd_t  cmd_o,
  input  cocp_pkg::dp_stat_t stat_i
);
  import cocp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ISSUE = 7'b0000010,
    S_WRAP  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_ROT   = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] op_q, op_d;
  logic       pass_q, pass_d;
  logic [2:0] mul_idx_q, mul_idx_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || m_ready_i;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pass_d      = pass_q;
    mul_idx_d   = mul_idx_q;
    cmd_o       = '0;
    cmd_o.red_src = SRC_ORBIT_DELTA;
    cmd_o.mul_idx = mul_idx_q;
    cmd_o.trig_sel = pass_q;

    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          op_d          = command_i;
          pass_d        = 1'b0;
          state_d       = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (op_q)
          CMD_ORBIT: begin
            cmd_o.red_start = 1'b1;
            cmd_o.red_src   = SRC_ORBIT_DELTA;
            state_d         = S_WRAP;
          end
          CMD_PITCH: begin
            cmd_o.apply_pitch = 1'b1;
            state_d           = S_DONE;
          end
          CMD_ZOOM: begin
            cmd_o.apply_zoom = 1'b1;
            state_d          = S_DONE;
          end
          CMD_UPDATE: begin
            cmd_o.red_start = 1'b1;
            cmd_o.red_src   = pass_q ? SRC_YAW_ORBIT : SRC_PITCH;
            state_d         = S_WRAP;
          end
          CMD_INIT: begin
            cmd_o.red_start  = 1'b1;
            cmd_o.red_src    = pass_q ? SRC_YAW_ORBIT : SRC_INIT_ORBIT;
            cmd_o.apply_init = !pass_q;
            state_d          = S_WRAP;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_WRAP: begin
        if (stat_i.red_done) begin
          case (op_q)
            CMD_ORBIT: begin
              cmd_o.wr_orbit = 1'b1;
              state_d        = S_DONE;
            end
            CMD_INIT: begin
              if (pass_q) begin
                cmd_o.wr_heading = 1'b1;
                state_d          = S_DONE;
              end else begin
                cmd_o.wr_orbit = 1'b1;
                pass_d         = 1'b1;
                state_d        = S_ISSUE;
              end
            end
            default: begin
              // update: theta pass also settles the heading
              cmd_o.wr_heading = pass_q;
              cmd_o.red_start  = 1'b1;
              cmd_o.red_src    = SRC_DIV;
              state_d          = S_DIV;
            end
          endcase
        end
      end
      S_DIV: begin
        if (stat_i.red_done) begin
          cmd_o.cordic_start = 1'b1;
          state_d            = S_ROT;
        end
      end
      S_ROT: begin
        if (stat_i.cordic_done) begin
          cmd_o.trig_store = 1'b1;
          if (pass_q) begin
            mul_idx_d = MUL_H;
            state_d   = S_MUL;
          end else begin
            pass_d  = 1'b1;
            state_d = S_ISSUE;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (mul_idx_q == MUL_POS) begin
          state_d = S_DONE;
        end else begin
          mul_idx_d = mul_idx_q + 3'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= CMD_ORBIT;
      pass_q      <= 1'b0;
      mul_idx_q   <= MUL_H;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      pass_q      <= pass_d;
      mul_idx_q   <= mul_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = out_valid_q;

  a_mul_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (mul_idx_q <= MUL_POS))
    else $error("multiplier step index out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_ready_i))
    else $error("pending result overwritten");

endmodule

// File: rtl/orbit_camera_position_core.sv
// ----------------------------------------------------------------------------
// orbit_camera_position_core
// third-person orbit camera: pitch, zoom, orbit and position update
// ----------------------------------------------------------------------------
// One command beat in, one result beat out, one item at a time. CORDIC_STEPS
// is capped at 24. Update runs two angles, one after the other, through the
// shared wrap/divide unit and the iterative cordic (one micro-rotation per
// cycle), then four products and the position step through one shared
// multiplier. The result sits in an output register, so a new command is
// taken while the previous result still waits on m_axis_tready; the next
// result then holds the sequencer until that register frees up. Config writes
// are meant for idle periods only.
module orbit_camera_position_core #(
  parameter int TRIG_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // command beat
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // delta[23:0], player_yaw[40:24], player_x[72:41], player_y[104:73],
  // player_z[136:105], zero pad up to 143
  input  logic [143:0] s_axis_tdata,
  // command[2:0]
  input  logic [2:0]   s_axis_tuser,
  // result beat
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // camera_x[31:0], camera_y[63:32], camera_z[95:64], camera_heading[111:96]
  output logic [111:0] m_axis_tdata,
  // config write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i
);
  import cocp_pkg::*;

  dp_cmd_t            dp_cmd;
  dp_stat_t           dp_stat;
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [15:0]        heading;

  // sequencer
  cocp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .command_i (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (dp_cmd),
    .stat_i    (dp_stat)
  );

  // state, arithmetic and result register
  cocp_datapath #(
    .TRIG_BITS    (TRIG_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .delta_i    (s_axis_tdata[23:0]),
    .yaw_i      (s_axis_tdata[40:24]),
    .px_i       (s_axis_tdata[72:41]),
    .py_i       (s_axis_tdata[104:73]),
    .pz_i       (s_axis_tdata[136:105]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cam_x_o    (cam_x),
    .cam_y_o    (cam_y),
    .cam_z_o    (cam_z),
    .heading_o  (heading)
  );

  assign m_axis_tdata = {heading, cam_z, cam_y, cam_x};

endmodule
